### src/q24alu_pkg.sv
// Shared types, constants and opcodes for the Q24.8 fixed-point ALU core.
// No dependencies; every other file in src uses this package by scoped names.
package q24alu_pkg;

    // Data path widths
    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;  // scaled dividend width
    localparam int DEN_W     = DATA_W;              // divisor magnitude width
    localparam int DIV_STEPS = NUM_W;               // one quotient bit per stage

    // Opcodes
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_EQ       = 4'd4,
        OP_NE       = 4'd5,
        OP_LT       = 4'd6,
        OP_GT       = 4'd7,
        OP_GE       = 4'd8,
        OP_LE       = 4'd9,
        OP_FROM_INT = 4'd10,
        OP_TO_INT   = 4'd11
    } op_t;

    // Input transaction
    typedef struct packed {
        logic [3:0]              cmd;
        logic signed [DATA_W-1:0] a_raw;
        logic signed [DATA_W-1:0] b_raw;
    } alu_in_t;

    // Output transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] result_raw;
        logic                     compare_true;
        logic                     div_by_zero;
    } alu_out_t;

    // Per-item control that rides alongside the divider
    typedef struct packed {
        logic     is_div;   // take the quotient at the end
        logic     neg;      // quotient sign
        alu_out_t res;      // finished result for every other case
    } side_t;

    // Restoring divider working set
    typedef struct packed {
        logic [NUM_W-1:0] dq;   // remaining dividend bits, quotient shifts in
        logic [DEN_W-1:0] rem;  // partial remainder
        logic [DEN_W-1:0] den;  // divisor magnitude
    } div_t;

endpackage

### src/q24alu_front.sv
// Front end of the ALU pipeline: input register, then the add, subtract, compare
// and conversion ops, the multiplier and the divider operand preparation. Uses q24alu_pkg.
module q24alu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  q24alu_pkg::alu_in_t  op_in,
    output logic                 vld_out,
    output q24alu_pkg::side_t    side_out,
    output q24alu_pkg::div_t     div_out
);

    logic                                   s1_vld_reg;
    q24alu_pkg::alu_in_t                    s1_op_reg;
    logic                                   s2_vld_reg;
    q24alu_pkg::side_t                      s2_side_reg;
    q24alu_pkg::div_t                       s2_div_reg;

    q24alu_pkg::side_t                      side_next;
    q24alu_pkg::div_t                       div_next;

    logic signed [q24alu_pkg::DATA_W-1:0]   a;
    logic signed [q24alu_pkg::DATA_W-1:0]   b;
    logic signed [2*q24alu_pkg::DATA_W-1:0] prod;
    logic signed [q24alu_pkg::NUM_W-1:0]    num;
    logic [q24alu_pkg::NUM_W-1:0]           num_mag;
    logic [q24alu_pkg::DEN_W-1:0]           den_mag;

    // Stage 1: capture the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
        begin
            s1_op_reg <= op_in;
        end
    end

    assign a = $signed(s1_op_reg.a_raw);
    assign b = $signed(s1_op_reg.b_raw);

    // Full signed product; the Q format keeps bits FRAC_BITS up
    assign prod = a * b;

    // Divider operands: dividend scaled by the fraction width, both as magnitudes
    assign num     = {a, {q24alu_pkg::FRAC_BITS{1'b0}}};
    assign num_mag = num[q24alu_pkg::NUM_W-1] ? q24alu_pkg::NUM_W'(-num)
                                               : q24alu_pkg::NUM_W'(num);
    assign den_mag = b[q24alu_pkg::DATA_W-1] ? q24alu_pkg::DEN_W'(-b)
                                              : q24alu_pkg::DEN_W'(b);

    // Result select for everything except the quotient
    always_comb
    begin
        side_next        = '0;
        side_next.neg    = a[q24alu_pkg::DATA_W-1] ^ b[q24alu_pkg::DATA_W-1];
        case (s1_op_reg.cmd)
            q24alu_pkg::OP_ADD:
                side_next.res.result_raw = a + b;
            q24alu_pkg::OP_SUB:
                side_next.res.result_raw = a - b;
            q24alu_pkg::OP_MUL:
                side_next.res.result_raw =
                    prod[q24alu_pkg::FRAC_BITS +: q24alu_pkg::DATA_W];
            q24alu_pkg::OP_DIV:
            begin
                if (b == '0)
                begin
                    // zero divisor: pass a through and flag it
                    side_next.res.result_raw  = a;
                    side_next.res.div_by_zero = 1'b1;
                end
                else
                begin
                    side_next.is_div = 1'b1;
                end
            end
            q24alu_pkg::OP_EQ:
                side_next.res.compare_true = (a == b);
            q24alu_pkg::OP_NE:
                side_next.res.compare_true = (a != b);
            q24alu_pkg::OP_LT:
                side_next.res.compare_true = (a < b);
            q24alu_pkg::OP_GT:
                side_next.res.compare_true = (a > b);
            q24alu_pkg::OP_GE:
                side_next.res.compare_true = (a >= b);
            q24alu_pkg::OP_LE:
                side_next.res.compare_true = (a <= b);
            q24alu_pkg::OP_FROM_INT:
                side_next.res.result_raw = a <<< q24alu_pkg::FRAC_BITS;
            q24alu_pkg::OP_TO_INT:
                side_next.res.result_raw = a >>> q24alu_pkg::FRAC_BITS;
            default:
                side_next.res = '0;
        endcase
    end

    always_comb
    begin
        div_next     = '0;
        div_next.dq  = num_mag;
        div_next.den = den_mag;
    end

    // Stage 2: results and divider seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_side_reg <= side_next;
            s2_div_reg  <= div_next;
        end
    end

    assign vld_out  = s2_vld_reg;
    assign side_out = s2_side_reg;
    assign div_out  = s2_div_reg;

endmodule

### src/q24alu_div_step.sv
// One stage of the pipelined restoring divider: one quotient bit per stage,
// with the item's side data carried along. Uses q24alu_pkg.
module q24alu_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  q24alu_pkg::side_t  side_in,
    input  q24alu_pkg::div_t   div_in,
    output logic               vld_out,
    output q24alu_pkg::side_t  side_out,
    output q24alu_pkg::div_t   div_out
);

    logic                          vld_reg;
    q24alu_pkg::side_t             side_reg;
    q24alu_pkg::div_t              div_reg;
    q24alu_pkg::div_t              div_next;

    logic [q24alu_pkg::DEN_W:0]    shifted;
    logic [q24alu_pkg::DEN_W:0]    diff;
    logic                          q_bit;

    // Bring down the next dividend bit and trial-subtract the divisor
    assign shifted = {div_in.rem, div_in.dq[q24alu_pkg::NUM_W-1]};
    assign diff    = shifted - {1'b0, div_in.den};
    assign q_bit   = ~diff[q24alu_pkg::DEN_W];

    always_comb
    begin
        div_next     = div_in;
        div_next.rem = q_bit ? diff[q24alu_pkg::DEN_W-1:0]
                             : shifted[q24alu_pkg::DEN_W-1:0];
        div_next.dq  = {div_in.dq[q24alu_pkg::NUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
        begin
            side_reg <= side_in;
            div_reg  <= div_next;
        end
    end

    assign vld_out  = vld_reg;
    assign side_out = side_reg;
    assign div_out  = div_reg;

endmodule

### src/fixed_point_q24_8_alu_core.sv
// Q24.8 ALU core: from the accepting edge to the done strobe an item passes the
// input register, operand stage, 40 divider stages and output register.
// Throughput one transaction per clock; every opcode runs the same pipeline.
// busy stays low: the pipeline never stalls since results cannot be held off.
// Reset (rst_n, async, active low) clears all valid bits; the pipe starts empty.
// Uses q24alu_pkg, q24alu_front and q24alu_div_step.
module fixed_point_q24_8_alu_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  q24alu_pkg::alu_in_t  operands,
    output logic                 done,
    output q24alu_pkg::alu_out_t result
);

    logic                    vld_s  [0:q24alu_pkg::DIV_STEPS];
    q24alu_pkg::side_t       side_s [0:q24alu_pkg::DIV_STEPS];
    q24alu_pkg::div_t        div_s  [0:q24alu_pkg::DIV_STEPS];

    logic                    done_reg;
    q24alu_pkg::alu_out_t    out_reg;
    q24alu_pkg::alu_out_t    out_next;

    logic [q24alu_pkg::DATA_W-1:0] quo;

    assign busy = 1'b0;

    // Operand register, add/sub/compare/convert ops, multiplier, divider seed
    q24alu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld_in   (start),
        .op_in    (operands),
        .vld_out  (vld_s[0]),
        .side_out (side_s[0]),
        .div_out  (div_s[0])
    );

    // Divider chain, one quotient bit per stage
    for (genvar i = 0; i < q24alu_pkg::DIV_STEPS; i++)
    begin : g_div
        q24alu_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (vld_s[i]),
            .side_in  (side_s[i]),
            .div_in   (div_s[i]),
            .vld_out  (vld_s[i+1]),
            .side_out (side_s[i+1]),
            .div_out  (div_s[i+1])
        );
    end

    // Apply the quotient sign; only the low word is kept
    assign quo = div_s[q24alu_pkg::DIV_STEPS].dq[q24alu_pkg::DATA_W-1:0];

    always_comb
    begin
        out_next = side_s[q24alu_pkg::DIV_STEPS].res;
        if (side_s[q24alu_pkg::DIV_STEPS].is_div)
        begin
            out_next.result_raw = side_s[q24alu_pkg::DIV_STEPS].neg ? -quo : quo;
        end
    end

    // Output register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_s[q24alu_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_s[q24alu_pkg::DIV_STEPS])
        begin
            out_reg <= out_next;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule
